FILE: hdl/hcs_pkg.sv
`default_nettype none

package hcs_pkg;

  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChBsl   = 8'h5C;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;

  typedef struct packed {
    logic       start_stream;
    logic [7:0] ch;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_beat_t;

endpackage

`default_nettype wire

FILE: hdl/hash_comment_stripper_top.sv
// A byte-producing input beat is registered and shows on the output in the cycle after acceptance.
// Throughput: one input beat per cycle if out_ready_i is high; an input that emits a held
// backslash plus its character holds both in the single output register, stalling input.
// Input ready depends only on the output register's occupancy and out_ready_i.
// Reset (rst_ni low, asynchronous): filter returns to plain text, output register empties.
`default_nettype none

module hash_comment_stripper_top (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire hcs_pkg::in_beat_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output hcs_pkg::out_beat_t     out_data_o
);
  import hcs_pkg::*;

  typedef enum logic [2:0] {
    StPlain      = 3'd0,
    StPlainBsl   = 3'd1,
    StQuote      = 3'd2,
    StQuoteBsl   = 3'd3,
    StComment    = 3'd4,
    StCommentBsl = 3'd5
  } filt_state_e;

  filt_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        pair_q, pair_d;
  logic [7:0]  byte_q;

  logic        in_fire;
  logic        out_fire;
  logic        emit_one;
  logic        emit_pair;
  logic        eol;
  logic [7:0]  ch;

  assign ch       = in_data_i.ch;
  assign eol      = (ch == ChLf) || (ch == ChCr);
  assign in_ready_o = !out_valid_q || (out_ready_i && !pair_q);
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_q && out_ready_i;

  assign out_valid_o         = out_valid_q;
  assign out_data_o.out_byte = pair_q ? ChBsl : byte_q;
  assign out_data_o.last     = !pair_q;

  always_comb begin
    state_d   = state_q;
    emit_one  = 1'b0;
    emit_pair = 1'b0;
    if (in_data_i.start_stream) begin
      state_d = StPlain;
    end else begin
      case (state_q)
        StPlain: begin
          if (ch == ChHash) begin
            state_d = StComment;
          end else if (ch == ChBsl) begin
            state_d = StPlainBsl;
          end else begin
            emit_one = 1'b1;
            if (ch == ChQuote) state_d = StQuote;
          end
        end
        StPlainBsl: begin
          emit_pair = 1'b1;
          state_d   = StPlain;
        end
        StQuote: begin
          if (ch == ChBsl) begin
            state_d = StQuoteBsl;
          end else begin
            emit_one = 1'b1;
            if (ch == ChQuote) state_d = StPlain;
          end
        end
        StQuoteBsl: begin
          emit_pair = 1'b1;
          state_d   = StQuote;
        end
        StComment: begin
          if (eol) begin
            state_d = StPlain;
          end else if (ch == ChBsl) begin
            state_d = StCommentBsl;
          end
        end
        StCommentBsl: begin
          if (!eol) state_d = StComment;
        end
        default: begin
          state_d = state_q;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    pair_d      = pair_q;
    if (out_fire) begin
      if (pair_q) begin
        pair_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
    if (in_fire && (emit_one || emit_pair)) begin
      out_valid_d = 1'b1;
      pair_d      = emit_pair;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StPlain;
      out_valid_q <= 1'b0;
      pair_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      pair_q      <= pair_d;
      if (in_fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && (emit_one || emit_pair)) begin
      byte_q <= ch;
    end
  end

  a_pair_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_q |-> out_valid_q)
    else $error("held backslash without valid output");

  a_pair_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && pair_q) |-> !in_ready_o)
    else $error("input accepted while a pair is pending");

  a_pair_then_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && pair_q) |=> (out_valid_o && out_data_o.last))
    else $error("second byte of pair missing");

  a_start_plain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.start_stream) |=> (state_q == StPlain))
    else $error("start marker did not return to plain");

  a_start_no_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.start_stream && (!out_valid_q || out_fire)) |=> !out_valid_q)
    else $error("start marker produced output");

endmodule

`default_nettype wire
